// ===== sv/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Types, codes and defaults shared by the code builder / encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hcb_pkg;

  localparam int SYMBOLS_DEF       = 256;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int DIST_W = 9;

  localparam logic [1:0] OP_COUNT  = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_ENCODE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_FEW      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [4:0] CMD_NOP      = 5'd0;
  localparam logic [4:0] CMD_ACCEPT   = 5'd1;
  localparam logic [4:0] CMD_CLEAR    = 5'd2;
  localparam logic [4:0] CMD_UNREADY  = 5'd3;
  localparam logic [4:0] CMD_C_WR     = 5'd4;
  localparam logic [4:0] CMD_FIN      = 5'd5;
  localparam logic [4:0] CMD_FIN_ENC  = 5'd6;
  localparam logic [4:0] CMD_BLD_INIT = 5'd7;
  localparam logic [4:0] CMD_LEAF_RD2 = 5'd8;
  localparam logic [4:0] CMD_LEAF_LD  = 5'd9;
  localparam logic [4:0] CMD_S_RD     = 5'd10;
  localparam logic [4:0] CMD_S_SHIFT  = 5'd11;
  localparam logic [4:0] CMD_S_PUT    = 5'd12;
  localparam logic [4:0] CMD_M_RDA    = 5'd13;
  localparam logic [4:0] CMD_M_RDB    = 5'd14;
  localparam logic [4:0] CMD_M_PAR_A  = 5'd15;
  localparam logic [4:0] CMD_M_PAR_B  = 5'd16;
  localparam logic [4:0] CMD_I_RD     = 5'd17;
  localparam logic [4:0] CMD_I_SHIFT  = 5'd18;
  localparam logic [4:0] CMD_I_PUT    = 5'd19;
  localparam logic [4:0] CMD_G_START  = 5'd20;
  localparam logic [4:0] CMD_G_NEXT   = 5'd21;
  localparam logic [4:0] CMD_G_UP     = 5'd22;
  localparam logic [4:0] CMD_G_STORE  = 5'd23;
  localparam logic [4:0] CMD_READY    = 5'd24;

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] symbol;
  } hcb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [DIST_W-1:0] distinct_count;
  } hcb_out_t;

  typedef struct packed {
    logic [4:0] code;
    logic [1:0] status;
  } hcb_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sym_bad;
    logic       total_full;
    logic       sym_seen;
    logic       ready;
    logic       few;
    logic       j_zero;
    logic       s_gt;
    logic       i_lt;
    logic       at_tail;
    logic       last_leaf;
    logic       last_pair;
    logic       s_seen;
    logic       is_root;
    logic       k_limit;
    logic       last_sym;
  } hcb_flags_t;

endpackage
`default_nettype wire

// ===== sv/hcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: decodes requests and steps the datapath through count, encode,
// clear and the sort / merge / code walk phases of a build.
// ----------------------------------------------------------------------------
`default_nettype none
module hcb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire hcb_pkg::hcb_flags_t flags,
  output hcb_pkg::hcb_cmd_t      cmd
);
  import hcb_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_CWR   = 5'd2;
  localparam logic [4:0] S_EFIN  = 5'd3;
  localparam logic [4:0] S_FIN   = 5'd4;
  localparam logic [4:0] S_LRD1  = 5'd5;
  localparam logic [4:0] S_LRD2  = 5'd6;
  localparam logic [4:0] S_LLD   = 5'd7;
  localparam logic [4:0] S_SCHK  = 5'd8;
  localparam logic [4:0] S_SCMP  = 5'd9;
  localparam logic [4:0] S_MA    = 5'd10;
  localparam logic [4:0] S_MB    = 5'd11;
  localparam logic [4:0] S_MP    = 5'd12;
  localparam logic [4:0] S_MQ    = 5'd13;
  localparam logic [4:0] S_ICHK  = 5'd14;
  localparam logic [4:0] S_ICMP  = 5'd15;
  localparam logic [4:0] S_GCHK  = 5'd16;
  localparam logic [4:0] S_GWALK = 5'd17;
  localparam logic [4:0] S_GUP   = 5'd18;
  localparam logic [4:0] S_GOK   = 5'd19;

  logic [4:0] state, state_next;
  logic [1:0] st, st_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    st_next    = st;
    cmd.code   = CMD_NOP;
    cmd.status = st;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.code   = CMD_ACCEPT;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (flags.op)
          OP_COUNT: begin
            if (flags.sym_bad) begin
              st_next    = ST_ABSENT;
              state_next = S_FIN;
            end else if (flags.total_full) begin
              st_next    = ST_OVERFLOW;
              state_next = S_FIN;
            end else begin
              state_next = S_CWR;
            end
          end
          OP_BUILD: begin
            if (flags.few) begin
              cmd.code   = CMD_UNREADY;
              st_next    = ST_FEW;
              state_next = S_FIN;
            end else begin
              cmd.code   = CMD_BLD_INIT;
              state_next = S_LRD1;
            end
          end
          OP_ENCODE: begin
            if (!flags.ready || flags.sym_bad || !flags.sym_seen) begin
              st_next    = ST_ABSENT;
              state_next = S_FIN;
            end else begin
              state_next = S_EFIN;
            end
          end
          default: begin
            cmd.code   = CMD_CLEAR;
            st_next    = ST_OK;
            state_next = S_FIN;
          end
        endcase
      end
      S_CWR: begin
        cmd.code   = CMD_C_WR;
        st_next    = ST_OK;
        state_next = S_FIN;
      end
      S_EFIN: begin
        cmd.code   = CMD_FIN_ENC;
        state_next = S_IDLE;
      end
      S_FIN: begin
        cmd.code   = CMD_FIN;
        state_next = S_IDLE;
      end
      S_LRD1: state_next = S_LRD2;
      S_LRD2: begin
        cmd.code   = CMD_LEAF_RD2;
        state_next = S_LLD;
      end
      S_LLD: begin
        cmd.code   = CMD_LEAF_LD;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (flags.j_zero) begin
          cmd.code   = CMD_S_PUT;
          state_next = flags.last_leaf ? S_MA : S_LRD1;
        end else begin
          cmd.code   = CMD_S_RD;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (flags.s_gt) begin
          cmd.code   = CMD_S_SHIFT;
          state_next = S_SCHK;
        end else begin
          cmd.code   = CMD_S_PUT;
          state_next = flags.last_leaf ? S_MA : S_LRD1;
        end
      end
      S_MA: begin
        cmd.code   = CMD_M_RDA;
        state_next = S_MB;
      end
      S_MB: begin
        cmd.code   = CMD_M_RDB;
        state_next = S_MP;
      end
      S_MP: begin
        cmd.code   = CMD_M_PAR_A;
        state_next = S_MQ;
      end
      S_MQ: begin
        cmd.code   = CMD_M_PAR_B;
        state_next = flags.last_pair ? S_GCHK : S_ICHK;
      end
      S_ICHK: begin
        if (flags.at_tail) begin
          cmd.code   = CMD_I_PUT;
          state_next = S_MA;
        end else begin
          cmd.code   = CMD_I_RD;
          state_next = S_ICMP;
        end
      end
      S_ICMP: begin
        if (flags.i_lt) begin
          cmd.code   = CMD_I_SHIFT;
          state_next = S_ICHK;
        end else begin
          cmd.code   = CMD_I_PUT;
          state_next = S_MA;
        end
      end
      S_GCHK: begin
        if (flags.s_seen) begin
          cmd.code   = CMD_G_START;
          state_next = S_GWALK;
        end else begin
          cmd.code   = CMD_G_NEXT;
          state_next = flags.last_sym ? S_GOK : S_GCHK;
        end
      end
      S_GWALK: begin
        if (flags.is_root) begin
          cmd.code   = CMD_G_STORE;
          state_next = flags.last_sym ? S_GOK : S_GCHK;
        end else if (flags.k_limit) begin
          st_next    = ST_OVERFLOW;
          state_next = S_FIN;
        end else begin
          state_next = S_GUP;
        end
      end
      S_GUP: begin
        cmd.code   = CMD_G_UP;
        state_next = S_GWALK;
      end
      S_GOK: begin
        cmd.code   = CMD_READY;
        st_next    = ST_OK;
        state_next = S_FIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hcb_dp.sv =====
// ----------------------------------------------------------------------------
// hcb_dp
// Datapath: symbol counts, first-seen order, merge list, parent links and
// code tables, with the counters and compares the sequencer steps through.
// ----------------------------------------------------------------------------
`default_nettype none
module hcb_dp #(
  parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hcb_pkg::hcb_in_t  item,
  input  wire hcb_pkg::hcb_cmd_t cmd,
  output hcb_pkg::hcb_flags_t    flags,
  output logic                   done,
  output hcb_pkg::hcb_out_t      result
);
  import hcb_pkg::*;

  localparam int IDX_W  = $clog2(SYMBOLS);
  localparam int CNT_W  = $clog2(SYMBOLS + 1);
  localparam int NODES  = 2 * SYMBOLS - 1;
  localparam int NODE_W = $clog2(NODES);
  localparam int LW     = COUNT_BITS + NODE_W;
  localparam int LIMIT  = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

  logic [COUNT_BITS-1:0] count_mem [SYMBOLS];
  logic [SYM_W-1:0]      first_mem [SYMBOLS];
  logic [LW-1:0]         list_mem  [SYMBOLS];
  logic [NODE_W:0]       par_mem   [NODES];
  logic [CODE_W-1:0]     cw_mem    [SYMBOLS];
  logic [LEN_W-1:0]      cl_mem    [SYMBOLS];

  logic [COUNT_BITS-1:0] count_rd;
  logic [SYM_W-1:0]      first_rd;
  logic [LW-1:0]         list_rd;
  logic [NODE_W:0]       par_rd;
  logic [CODE_W-1:0]     cw_rd;
  logic [LEN_W-1:0]      cl_rd;

  logic [SYMBOLS-1:0]    seen;
  logic [CNT_W-1:0]      distinct;
  logic [COUNT_BITS-1:0] total;
  logic                  ready;
  logic [1:0]            op_r;
  logic [SYM_W-1:0]      sym_r;

  logic [CNT_W-1:0]      i, j, head, len;
  logic [NODE_W-1:0]     next, root, node, cur_node, a_node, b_node;
  logic [COUNT_BITS-1:0] cur_w, a_w;
  logic [IDX_W-1:0]      s;
  logic [LEN_W-1:0]      k;
  logic [CODE_W-1:0]     code;

  logic [IDX_W-1:0]      sym_idx, count_ra, first_ra, list_ra, list_wa;
  logic [LW-1:0]         list_wd;
  logic                  list_we;
  logic [COUNT_BITS-1:0] list_rd_w;
  logic [NODE_W-1:0]     list_rd_node;
  logic [CNT_W-1:0]      tail;

  assign sym_idx      = sym_r[IDX_W-1:0];
  assign list_rd_w    = list_rd[LW-1:NODE_W];
  assign list_rd_node = list_rd[NODE_W-1:0];
  assign tail         = CNT_W'(head + len);
  assign count_ra     = (cmd.code == CMD_LEAF_RD2) ? first_rd[IDX_W-1:0] : sym_idx;
  assign first_ra     = IDX_W'(distinct - CNT_W'(1) - i);

  always_comb begin
    case (cmd.code)
      CMD_S_RD:  list_ra = IDX_W'(j - CNT_W'(1));
      CMD_M_RDA: list_ra = IDX_W'(head);
      CMD_M_RDB: list_ra = IDX_W'(head + CNT_W'(1));
      default:   list_ra = IDX_W'(j);
    endcase
  end

  always_comb begin
    list_we = 1'b0;
    list_wa = IDX_W'(j);
    list_wd = list_rd;
    case (cmd.code)
      CMD_S_SHIFT: list_we = 1'b1;
      CMD_S_PUT: begin
        list_we = 1'b1;
        list_wd = {cur_w, cur_node};
      end
      CMD_I_SHIFT: begin
        list_we = 1'b1;
        list_wa = IDX_W'(j - CNT_W'(1));
      end
      CMD_I_PUT: begin
        list_we = 1'b1;
        list_wa = IDX_W'(j - CNT_W'(1));
        list_wd = {cur_w, cur_node};
      end
      default: list_we = 1'b0;
    endcase
  end

  always_comb begin
    flags.op         = op_r;
    flags.sym_bad    = (DIST_W'(sym_r) >= DIST_W'(SYMBOLS));
    flags.total_full = &total;
    flags.sym_seen   = seen[sym_idx];
    flags.ready      = ready;
    flags.few        = (distinct < CNT_W'(2));
    flags.j_zero     = (j == '0);
    flags.s_gt       = (list_rd_w > cur_w);
    flags.i_lt       = (list_rd_w < cur_w);
    flags.at_tail    = (j == tail);
    flags.last_leaf  = (i == distinct - CNT_W'(1));
    flags.last_pair  = (len == CNT_W'(2));
    flags.s_seen     = seen[s];
    flags.is_root    = (node == root);
    flags.k_limit    = (k >= LEN_W'(LIMIT));
    flags.last_sym   = (s == IDX_W'(SYMBOLS - 1));
  end

  // memories
  always_ff @(posedge clk) begin
    count_rd <= count_mem[count_ra];
    first_rd <= first_mem[first_ra];
    list_rd  <= list_mem[list_ra];
    par_rd   <= par_mem[node];
    cw_rd    <= cw_mem[sym_idx];
    cl_rd    <= cl_mem[sym_idx];
    if (cmd.code == CMD_C_WR) begin
      count_mem[sym_idx] <= seen[sym_idx] ? count_rd + COUNT_BITS'(1) : COUNT_BITS'(1);
      if (!seen[sym_idx]) begin
        first_mem[distinct[IDX_W-1:0]] <= sym_r;
      end
    end
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (cmd.code == CMD_M_PAR_A) begin
      par_mem[a_node] <= {next, 1'b0};
    end else if (cmd.code == CMD_M_PAR_B) begin
      par_mem[b_node] <= {next, 1'b1};
    end
    if (cmd.code == CMD_G_STORE) begin
      cw_mem[s] <= code;
      cl_mem[s] <= k;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      distinct <= '0;
      total    <= '0;
      ready    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= (cmd.code == CMD_FIN) || (cmd.code == CMD_FIN_ENC);
      case (cmd.code)
        CMD_CLEAR: begin
          seen     <= '0;
          distinct <= '0;
          total    <= '0;
          ready    <= 1'b0;
        end
        CMD_C_WR: begin
          seen[sym_idx] <= 1'b1;
          if (!seen[sym_idx]) begin
            distinct <= distinct + CNT_W'(1);
          end
          total <= total + COUNT_BITS'(1);
          ready <= 1'b0;
        end
        CMD_UNREADY:  ready <= 1'b0;
        CMD_BLD_INIT: ready <= 1'b0;
        CMD_READY:    ready <= 1'b1;
        default:      ready <= ready;
      endcase
    end
  end

  // build working registers and result
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_ACCEPT: begin
        op_r  <= item.op;
        sym_r <= item.symbol;
      end
      CMD_FIN: begin
        result.status         <= cmd.status;
        result.code_bits      <= '0;
        result.code_length    <= '0;
        result.distinct_count <= DIST_W'(distinct);
      end
      CMD_FIN_ENC: begin
        result.status         <= ST_OK;
        result.code_bits      <= cw_rd;
        result.code_length    <= cl_rd;
        result.distinct_count <= DIST_W'(distinct);
      end
      CMD_BLD_INIT: begin
        i    <= '0;
        len  <= '0;
        head <= '0;
        next <= NODE_W'(SYMBOLS);
      end
      CMD_LEAF_RD2: cur_node <= NODE_W'(first_rd);
      CMD_LEAF_LD: begin
        cur_w <= count_rd;
        j     <= len;
      end
      CMD_S_SHIFT: j <= j - CNT_W'(1);
      CMD_S_PUT: begin
        len <= len + CNT_W'(1);
        i   <= i + CNT_W'(1);
      end
      CMD_M_RDB: begin
        a_w    <= list_rd_w;
        a_node <= list_rd_node;
      end
      CMD_M_PAR_A: begin
        cur_w    <= a_w + list_rd_w;
        cur_node <= next;
        b_node   <= list_rd_node;
      end
      CMD_M_PAR_B: begin
        head <= head + CNT_W'(2);
        j    <= head + CNT_W'(2);
        len  <= len - CNT_W'(2);
        next <= next + NODE_W'(1);
        root <= cur_node;
        s    <= '0;
      end
      CMD_I_SHIFT: j <= j + CNT_W'(1);
      CMD_I_PUT: begin
        head <= head - CNT_W'(1);
        len  <= len + CNT_W'(1);
      end
      CMD_G_START: begin
        node <= NODE_W'(s);
        k    <= '0;
        code <= '0;
      end
      CMD_G_UP: begin
        code[k[4:0]] <= par_rd[0];
        k            <= k + LEN_W'(1);
        node         <= par_rd[NODE_W:1];
      end
      CMD_G_NEXT:  s <= s + IDX_W'(1);
      CMD_G_STORE: s <= s + IDX_W'(1);
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/huffman_code_builder_encoder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_encoder_top
// Byte-alphabet Huffman code builder and encoder.
// Count: idle accept, then dispatch, count-write and finish states, then the
// result strobe; encode, clear and refused requests skip count-write. Build:
// insertion sort and merge-list inserts scan the list memory entry by entry
// (order n^2 for n symbols), then the parent walk climbs from each seen symbol.
// busy drops in the result cycle; start may be taken in that same cycle.
// Synchronous reset clears seen flags, distinct/total counters, code-ready.
// ----------------------------------------------------------------------------
`default_nettype none
module huffman_code_builder_encoder_top #(
  parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire hcb_pkg::hcb_in_t  item,
  output logic                   done,
  output hcb_pkg::hcb_out_t      result
);
  import hcb_pkg::*;

  hcb_cmd_t   cmd;
  hcb_flags_t flags;

  hcb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  hcb_dp #(
    .SYMBOLS       (SYMBOLS),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_len_max: assert property (@(posedge clk) disable iff (rst)
      done |-> (result.code_length <= LEN_W'(CODE_W)))
    else $error("code length above limit");
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
      (done && result.status != ST_OK) |-> (result.code_length == '0))
    else $error("failed request carries a code");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule
`default_nettype wire

// ===== tb/huffman_code_builder_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_encoder_top_tb
// Drives count, build, encode and clear beats into the Huffman code builder.
// Every accepted beat is run through an in-bench copy of the builder
// (counts, first-seen order, list merge, parent walk), and each result
// strobe is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none
module huffman_code_builder_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcb_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  hcb_in_t  item;
  logic     done;
  hcb_out_t result;

  huffman_code_builder_encoder_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  // builder shadow state
  int          sym_count [256];
  int          seen_order [256];
  int          distinct_n;
  int          msg_total;
  logic [31:0] code_word [256];
  int          code_len [256];
  bit          codes_ready;

  hcb_out_t    pending_results[$];
  int          fails;
  int          send_gap_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("huffman_code_builder_encoder_top_tb: errors");
    $finish;
  end

  function automatic void clear_shadow();
    for (int s = 0; s < 256; s++) begin
      sym_count[s] = 0;
      seen_order[s] = 0;
      code_word[s] = '0;
      code_len[s] = 0;
    end
    distinct_n = 0;
    msg_total = 0;
    codes_ready = 0;
  endfunction

  function automatic logic [1:0] build_codes();
    int n;
    int wt [511];
    int par [511];
    int lst [256];
    int len, nx, root, pos, v, j, a, b, sum, node, k;
    logic [31:0] cw;
    n = distinct_n;
    codes_ready = 0;
    if (n < 2) return ST_FEW;
    for (int i = 0; i < n; i++) begin
      lst[i] = seen_order[n - 1 - i];
      wt[lst[i]] = sym_count[lst[i]];
    end
    for (int i = 1; i < n; i++) begin
      v = lst[i];
      j = i;
      while (j > 0 && wt[lst[j - 1]] > wt[v]) begin
        lst[j] = lst[j - 1];
        j--;
      end
      lst[j] = v;
    end
    len = n;
    nx = 256;
    while (len >= 2 && nx < 511) begin
      a = lst[0];
      b = lst[1];
      sum = (wt[a] + wt[b]) & 16'hffff;
      wt[nx] = sum;
      par[a] = nx * 2;
      par[b] = nx * 2 + 1;
      for (int i = 0; i < len - 2; i++) lst[i] = lst[i + 2];
      len -= 2;
      nx++;
      if (len == 0) break;
      pos = 0;
      while (pos < len && wt[lst[pos]] < sum) pos++;
      for (int i = len; i > pos; i--) lst[i] = lst[i - 1];
      lst[pos] = nx - 1;
      len++;
    end
    root = nx - 1;
    for (int s = 0; s < 256; s++) code_len[s] = 0;
    for (int s = 0; s < 256; s++) begin
      if (sym_count[s] == 0) continue;
      node = s;
      k = 0;
      cw = '0;
      while (node != root) begin
        if (k >= 32) begin
          for (int t = 0; t < 256; t++) code_len[t] = 0;
          return ST_OVERFLOW;
        end
        cw[k] = par[node][0];
        k++;
        node = par[node] >> 1;
      end
      code_word[s] = cw;
      code_len[s] = k;
    end
    codes_ready = 1;
    return ST_OK;
  endfunction

  function automatic hcb_out_t predict_step(hcb_in_t b);
    hcb_out_t r;
    int s;
    r = '0;
    s = int'(b.symbol);
    case (b.op)
      OP_COUNT: begin
        if (msg_total >= 65535) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (sym_count[s] == 0 && distinct_n < 256) begin
            seen_order[distinct_n] = s;
            distinct_n++;
          end
          sym_count[s]++;
          msg_total++;
          codes_ready = 0;
        end
      end
      OP_BUILD: r.status = build_codes();
      OP_ENCODE: begin
        if (!codes_ready || code_len[s] == 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.code_bits = code_word[s];
          r.code_length = LEN_W'(code_len[s]);
        end
      end
      default: clear_shadow();
    endcase
    r.distinct_count = DIST_W'(distinct_n);
    return r;
  endfunction

  always @(posedge clk) begin
    hcb_out_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, result.status);
          fails++;
        end
        if (result.code_bits !== exp_r.code_bits) begin
          $error("code_bits exp %h got %h", exp_r.code_bits, result.code_bits);
          fails++;
        end
        if (result.code_length !== exp_r.code_length) begin
          $error("code_length exp %0d got %0d", exp_r.code_length, result.code_length);
          fails++;
        end
        if (result.distinct_count !== exp_r.distinct_count) begin
          $error("distinct_count exp %0d got %0d",
                 exp_r.distinct_count, result.distinct_count);
          fails++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_beat(logic [1:0] op, logic [7:0] sym);
    hcb_in_t b;
    if ($urandom_range(99) < send_gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    b.op = op;
    b.symbol = sym;
    item = b;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(predict_step(b));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    send_beat(OP_ENCODE, 8'h00);
    send_beat(OP_BUILD, 8'h00);
    send_beat(OP_COUNT, 8'hff);
    send_beat(OP_BUILD, 8'hff);
    send_beat(OP_COUNT, 8'h00);
    send_beat(OP_COUNT, 8'h00);
    send_beat(OP_COUNT, 8'h5a);
    send_beat(OP_BUILD, 8'h00);
    send_beat(OP_ENCODE, 8'h00);
    send_beat(OP_ENCODE, 8'hff);
    send_beat(OP_ENCODE, 8'h5a);
    send_beat(OP_ENCODE, 8'ha5);
    send_beat(OP_COUNT, 8'ha5);
    send_beat(OP_ENCODE, 8'h00);
    send_beat(OP_BUILD, 8'h00);
    send_beat(OP_ENCODE, 8'ha5);
    send_beat(OP_CLEAR, 8'h00);
    send_beat(OP_ENCODE, 8'h00);
    send_beat(OP_BUILD, 8'h00);
    drain();
  endtask

  task automatic test_random(int beats);
    int sent;
    int alpha_n;
    logic [7:0] alpha [40];
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(3) != 0) send_beat(OP_CLEAR, 8'($urandom));
      else send_beat(OP_COUNT, 8'($urandom));
      alpha_n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < alpha_n; i++) alpha[i] = 8'($urandom);
      repeat ($urandom_range(alpha_n, 3 * alpha_n + 4)) begin
        send_beat(OP_COUNT, alpha[$urandom_range(alpha_n - 1)]);
        sent++;
      end
      if ($urandom_range(4) == 0) send_beat(OP_ENCODE, alpha[0]);
      send_beat(OP_BUILD, 8'($urandom));
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(4) == 0) send_beat(OP_ENCODE, 8'($urandom));
        else send_beat(OP_ENCODE, alpha[$urandom_range(alpha_n - 1)]);
        sent++;
      end
      if ($urandom_range(5) == 0) begin
        send_beat(OP_COUNT, alpha[0]);
        send_beat(OP_ENCODE, alpha[0]);
      end
      sent += 3;
    end
    drain();
  endtask

  task automatic test_full_alphabet();
    send_beat(OP_CLEAR, 8'h00);
    for (int s = 0; s < 256; s++) begin
      repeat ((s % 2) + 1) send_beat(OP_COUNT, 8'(255 - s));
    end
    send_beat(OP_BUILD, 8'h00);
    for (int s = 0; s < 256; s += 17) send_beat(OP_ENCODE, 8'(s));
    send_beat(OP_ENCODE, 8'hff);
    drain();
  endtask

  initial begin
    fails = 0;
    send_gap_pct = 22;
    clear_shadow();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(120);
    send_gap_pct = 63;
    test_random(120);
    send_gap_pct = 0;
    test_random(120);
    test_full_alphabet();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("huffman_code_builder_encoder_top_tb: clean");
    end else begin
      $display("huffman_code_builder_encoder_top_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/hcb_pkg.sv
sv/hcb_ctrl.sv
sv/hcb_dp.sv
sv/huffman_code_builder_encoder_top.sv
tb/huffman_code_builder_encoder_top_tb.sv
